>>> hw/rtl/vwd_pkg.sv
// shared types and constants for the vertex weld dedup table
// no dependencies; used by every module under hw/rtl
package vwd_pkg;

    localparam int NODE_CAPACITY = 4096;
    localparam int ADDR_W        = $clog2(NODE_CAPACITY);
    localparam int CNT_W         = $clog2(NODE_CAPACITY + 1);

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int TOL_W   = 52;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [11:0]       node_index_t;
    typedef logic [12:0]       node_count_t;
    typedef logic [TOL_W-1:0]  tol_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } vertex_t;

    typedef struct packed {
        node_index_t node_index;
        logic        was_new;
        logic        table_full;
        node_count_t node_count;
    } result_t;

    // compare stage output of the distance pipe
    typedef struct packed {
        logic  valid;
        logic  hit;
        addr_t tag;
    } dist_res_t;

endpackage

>>> hw/rtl/vwd_node_ram.sv
// node store: one write port, one read port with registered read data
// depends on vwd_pkg
module vwd_node_ram (
    input  logic             clk,
    input  logic             wr_en,
    input  vwd_pkg::addr_t   wr_addr,
    input  vwd_pkg::vertex_t wr_data,
    input  logic             rd_en,
    input  vwd_pkg::addr_t   rd_addr,
    output vwd_pkg::vertex_t rd_data
);

    vwd_pkg::vertex_t mem [vwd_pkg::NODE_CAPACITY];
    vwd_pkg::vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/vwd_dist_pipe.sv
// three-stage squared distance pipe: difference, square, sum and compare
// depends on vwd_pkg
module vwd_dist_pipe (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               flush,
    input  logic               in_valid,
    input  vwd_pkg::addr_t     in_tag,
    input  vwd_pkg::vertex_t   node,
    input  vwd_pkg::vertex_t   vertex,
    input  vwd_pkg::tol_t      tolerance_sq,
    output vwd_pkg::dist_res_t res,
    output logic               pipe_busy
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s3_hit_reg;
    vwd_pkg::addr_t s1_tag_reg, s2_tag_reg, s3_tag_reg;

    logic signed [vwd_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [vwd_pkg::DIFF_W-1:0] dx_next, dy_next, dz_next;
    logic signed [vwd_pkg::PROD_W-1:0] px, py, pz;
    logic [vwd_pkg::SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [vwd_pkg::SUM_W-1:0]         sum;
    logic                              hit_next;

    always_comb
    begin
        dx_next = {node.coord_x[vwd_pkg::COORD_W-1], node.coord_x}
                - {vertex.coord_x[vwd_pkg::COORD_W-1], vertex.coord_x};
        dy_next = {node.coord_y[vwd_pkg::COORD_W-1], node.coord_y}
                - {vertex.coord_y[vwd_pkg::COORD_W-1], vertex.coord_y};
        dz_next = {node.coord_z[vwd_pkg::COORD_W-1], node.coord_z}
                - {vertex.coord_z[vwd_pkg::COORD_W-1], vertex.coord_z};
        px = dx_reg * dx_reg;
        py = dy_reg * dy_reg;
        pz = dz_reg * dz_reg;
        // each square is below 2^48, the sum below 2^50
        sum = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};
        hit_next = ({{(vwd_pkg::TOL_W - vwd_pkg::SUM_W){1'b0}}, sum} < tolerance_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        s1_tag_reg <= in_tag;
        sqx_reg    <= px[vwd_pkg::SQ_W-1:0];
        sqy_reg    <= py[vwd_pkg::SQ_W-1:0];
        sqz_reg    <= pz[vwd_pkg::SQ_W-1:0];
        s2_tag_reg <= s1_tag_reg;
        s3_hit_reg <= hit_next;
        s3_tag_reg <= s2_tag_reg;
    end

    assign res.valid = s3_valid_reg;
    assign res.hit   = s3_hit_reg;
    assign res.tag   = s3_tag_reg;
    assign pipe_busy = s1_valid_reg | s2_valid_reg | s3_valid_reg;

endmodule

>>> hw/rtl/vertex_weld_dedup_table.sv
// vertex weld dedup table: scans stored nodes in order for the first one within
// the squared tolerance, otherwise appends it if the table has room (else it
// flags table_full); one memory read per cycle while scanning; busy stays high
// until the result strobe, and the next start is taken only once busy is low
// reset empties the table and clears tolerance_sq; the receiver cannot stall
module vertex_weld_dedup_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vwd_pkg::vertex_t vertex,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  vwd_pkg::tol_t    cfg_data,
    output vwd_pkg::result_t result,
    output logic             result_valid
);

    typedef enum logic [0:0] {
        IDLE,
        SCAN
    } state_t;

    state_t             state_reg;
    vwd_pkg::vertex_t   vertex_reg;
    vwd_pkg::count_t    count_reg;
    vwd_pkg::count_t    issue_reg;
    vwd_pkg::tol_t      tol_reg;
    vwd_pkg::result_t   result_reg;
    logic               strobe_reg;
    logic               rd_valid_reg;
    vwd_pkg::addr_t     rd_tag_reg;

    logic               issue;
    logic               hit_found;
    logic               miss_done;
    logic               table_has_room;
    logic               wr_en;
    logic               pipe_busy;
    vwd_pkg::vertex_t   rd_data;
    vwd_pkg::dist_res_t res;
    vwd_pkg::count_t    count_next;

    assign issue          = (state_reg == SCAN) && (issue_reg < count_reg);
    assign hit_found      = (state_reg == SCAN) && res.valid && res.hit;
    assign miss_done      = (state_reg == SCAN) && !issue && !rd_valid_reg && !pipe_busy;
    assign table_has_room = (count_reg < vwd_pkg::count_t'(vwd_pkg::NODE_CAPACITY));
    assign wr_en          = miss_done && table_has_room;
    assign count_next     = wr_en ? count_reg + 1'b1 : count_reg;

    assign busy      = (state_reg != IDLE);
    // a tolerance write never lands on the edge that takes a vertex
    assign cfg_ready = (state_reg == IDLE) && !start;

    vwd_node_ram u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[vwd_pkg::ADDR_W-1:0]),
        .wr_data (vertex_reg),
        .rd_en   (issue),
        .rd_addr (issue_reg[vwd_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    vwd_dist_pipe u_dist_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .flush        (hit_found),
        .in_valid     (rd_valid_reg),
        .in_tag       (rd_tag_reg),
        .node         (rd_data),
        .vertex       (vertex_reg),
        .tolerance_sq (tol_reg),
        .res          (res),
        .pipe_busy    (pipe_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            tol_reg      <= '0;
            strobe_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            strobe_reg   <= 1'b0;
            rd_valid_reg <= issue && !hit_found;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        issue_reg <= '0;
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (issue)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    // first hit out of the pipe is the earliest node, later ones are flushed
                    if (hit_found || miss_done)
                    begin
                        strobe_reg <= 1'b1;
                        count_reg  <= count_next;
                        state_reg  <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag_reg <= issue_reg[vwd_pkg::ADDR_W-1:0];
        if ((state_reg == IDLE) && start)
        begin
            vertex_reg <= vertex;
        end
        if (hit_found)
        begin
            result_reg.node_index <= vwd_pkg::node_index_t'(res.tag);
            result_reg.was_new    <= 1'b0;
            result_reg.table_full <= 1'b0;
            result_reg.node_count <= vwd_pkg::node_count_t'(count_reg);
        end
        else if (miss_done)
        begin
            result_reg.node_index <= table_has_room ? vwd_pkg::node_index_t'(count_reg) : '0;
            result_reg.was_new    <= table_has_room;
            result_reg.table_full <= !table_has_room;
            result_reg.node_count <= vwd_pkg::node_count_t'(count_next);
        end
    end

    assign result       = result_reg;
    assign result_valid = strobe_reg;

endmodule
